// ===== hw/rtl/bpqel_pkg.sv =====
// Shared types and constants for the bounded priority queue with lowest eviction.
// Used by the channel interfaces and the top level; depends on nothing.
`default_nettype none

package bpqel_pkg;

    localparam int VAL_W    = 32;   // value and priority width
    localparam int STAMP_W  = 32;   // insertion stamp width
    localparam int CAP_W    = 5;    // capacity register width
    localparam int ST_W     = 3;    // status code width
    localparam int FILL_W   = 5;    // reported fill width

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [ST_W-1:0] {
        ST_APPEND  = 3'd0,
        ST_REPLACE = 3'd1,
        ST_DROP    = 3'd2,
        ST_REMOVE  = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

endpackage

`default_nettype wire

// ===== hw/rtl/bpqel_if.sv =====
// Valid/ready channel interfaces for the queue's request and result items.
// Depends on bpqel_pkg for field widths.
`default_nettype none

interface bpqel_in_if;
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic signed [bpqel_pkg::VAL_W-1:0]  value;
    logic signed [bpqel_pkg::VAL_W-1:0]  priority_req;

    modport source (output valid, output op, output value, output priority_req, input ready);
    modport sink   (input valid, input op, input value, input priority_req, output ready);
endinterface

interface bpqel_out_if;
    logic                                valid;
    logic                                ready;
    logic [bpqel_pkg::ST_W-1:0]          status;
    logic signed [bpqel_pkg::VAL_W-1:0]  out_value;
    logic signed [bpqel_pkg::VAL_W-1:0]  out_priority;
    logic [bpqel_pkg::FILL_W-1:0]        fill;

    modport source (output valid, output status, output out_value, output out_priority,
                    output fill, input ready);
    modport sink   (input valid, input status, input out_value, input out_priority,
                    input fill, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bounded_priority_queue_evict_lowest_unit.sv =====
// Bounded priority queue; when full, a higher-priority enqueue evicts the first lowest entry.
// From accept: append writes the tail, then done; an empty dequeue goes straight to done.
// A full enqueue or a dequeue scans all held entries, then decides; a dequeue not of the
// last entry then shifts later entries down. One item at a time: the next is taken once
// the result is registered; the single memory read port sets the cost, one entry per cycle.
// Reset (synchronous, active low): queue empty, stamp counter zero, capacity 16.
`default_nettype none

module bounded_priority_queue_evict_lowest_unit #(
    parameter int DEPTH = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [bpqel_pkg::CAP_W-1:0]       i_cfg_data,
    bpqel_in_if.sink                         i_in,
    bpqel_out_if.source                      o_out
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // entry index width
    localparam int FW = $clog2(DEPTH + 1);                  // fill count width
    localparam int EW = (FW > bpqel_pkg::CAP_W) ? FW : bpqel_pkg::CAP_W;
    localparam int VW = bpqel_pkg::VAL_W;
    localparam int SW = bpqel_pkg::STAMP_W;

    // Sequencer: one-hot states.
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_APPEND = 6'b000010,
        S_SCAN   = 6'b000100,
        S_DECIDE = 6'b001000,
        S_SHIFT  = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state                     r_state, n_state;

    // Entry memory: one read port, one write port, registered read data.
    logic        [VW-1:0]       r_mem_val   [DEPTH];
    logic        [VW-1:0]       r_mem_pri   [DEPTH];
    logic        [SW-1:0]       r_mem_stamp [DEPTH];
    logic signed [VW-1:0]       r_rd_val;
    logic signed [VW-1:0]       r_rd_pri;
    logic        [SW-1:0]       r_rd_stamp;

    // Control state.
    logic [FW-1:0]              r_fill;
    logic [SW-1:0]              r_stamp;
    logic [bpqel_pkg::CAP_W-1:0] r_cap;
    logic [AW-1:0]              r_idx;      // read address being issued
    logic                       r_issue;    // reads still to issue
    logic                       r_rd_vld;   // read data registered this cycle
    logic [AW-1:0]              r_rd_idx;   // address of the registered read data
    logic                       r_first;    // next compare is the first of the scan
    logic                       r_out_valid;

    // Captured request and running best/worst entry.
    logic                       r_op;
    logic signed [VW-1:0]       r_val;
    logic signed [VW-1:0]       r_pri;
    logic [AW-1:0]              r_best_idx;
    logic signed [VW-1:0]       r_best_val;
    logic signed [VW-1:0]       r_best_pri;
    logic        [SW-1:0]       r_best_stamp;

    // Pending result and output register.
    bpqel_pkg::t_status         r_res_status;
    logic signed [VW-1:0]       r_res_val;
    logic signed [VW-1:0]       r_res_pri;
    logic [bpqel_pkg::ST_W-1:0] r_out_status;
    logic signed [VW-1:0]       r_out_val;
    logic signed [VW-1:0]       r_out_pri;
    logic [bpqel_pkg::FILL_W-1:0] r_out_fill;

    // Combinational helpers.
    logic                       w_accept;
    logic [AW-1:0]              w_last_idx;
    logic [EW-1:0]              w_cap_ext;
    logic [EW-1:0]              w_depth;
    logic [EW-1:0]              w_cap_eff;
    logic                       w_room;
    logic                       w_take;
    logic                       w_scan_end;
    logic                       w_out_free;
    logic                       w_we;
    logic [AW-1:0]              w_waddr;
    logic [VW-1:0]              w_wval;
    logic [VW-1:0]              w_wpri;
    logic [SW-1:0]              w_wstamp;

    assign w_accept   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // Index of the last held entry; only used while at least one entry is held.
    assign w_last_idx = AW'(r_fill - FW'(1));

    // Capacity zero acts as one, capacity above DEPTH saturates.
    assign w_cap_ext = EW'(r_cap);
    assign w_depth   = EW'(DEPTH);
    assign w_cap_eff = (w_cap_ext == '0)     ? EW'(1)  :
                       (w_cap_ext > w_depth) ? w_depth : w_cap_ext;
    assign w_room    = (EW'(r_fill) < w_cap_eff);

    // Shared compare unit. Enqueue hunts the first lowest priority; dequeue the
    // highest priority with the oldest stamp winning ties.
    always_comb begin
        if (r_first) begin
            w_take = 1'b1;
        end else if (r_op == bpqel_pkg::OP_ENQ) begin
            w_take = (r_rd_pri < r_best_pri);
        end else begin
            w_take = (r_rd_pri > r_best_pri) ||
                     ((r_rd_pri == r_best_pri) && (r_rd_stamp < r_best_stamp));
        end
    end

    // The read pipeline has drained once nothing is issued and the last data is in.
    assign w_scan_end = !r_issue && r_rd_vld;
    assign w_out_free = !r_out_valid || o_out.ready;

    // Write port: append at the tail, replace the victim, or move an entry down.
    always_comb begin
        w_we     = 1'b0;
        w_waddr  = r_fill[AW-1:0];
        w_wval   = r_val;
        w_wpri   = r_pri;
        w_wstamp = r_stamp;
        case (r_state)
            S_APPEND: begin
                w_we = 1'b1;
            end
            S_DECIDE: begin
                w_waddr = r_best_idx;
                w_we    = (r_op == bpqel_pkg::OP_ENQ) && (r_pri > r_best_pri);
            end
            S_SHIFT: begin
                w_we     = r_rd_vld;
                w_waddr  = r_rd_idx - AW'(1);
                w_wval   = r_rd_val;
                w_wpri   = r_rd_pri;
                w_wstamp = r_rd_stamp;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem_val[w_waddr]   <= w_wval;
            r_mem_pri[w_waddr]   <= w_wpri;
            r_mem_stamp[w_waddr] <= w_wstamp;
        end
        r_rd_val   <= r_mem_val[r_idx];
        r_rd_pri   <= r_mem_pri[r_idx];
        r_rd_stamp <= r_mem_stamp[r_idx];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in.op == bpqel_pkg::OP_ENQ) begin
                        n_state = w_room ? S_APPEND : S_SCAN;
                    end else begin
                        n_state = (r_fill == '0) ? S_DONE : S_SCAN;
                    end
                end
            end
            S_APPEND: begin
                n_state = S_DONE;
            end
            S_SCAN: begin
                if (w_scan_end) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if ((r_op == bpqel_pkg::OP_DEQ) && (r_best_idx != w_last_idx)) begin
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (w_scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_stamp     <= '0;
            r_cap       <= bpqel_pkg::CAP_RESET;
            r_idx       <= '0;
            r_issue     <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // The user must write the capacity only while idle; the block itself does not enforce it.
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end

            // Drop the result once taken; a new one loads in the done state.
            if (o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            // Read pipeline advance, shared by scan and shift. Nothing is in
            // flight in the idle and decide states, so the valid flag drops there.
            r_rd_vld <= r_issue;
            r_rd_idx <= r_idx;
            if (r_issue) begin
                if (r_idx == w_last_idx) begin
                    r_issue <= 1'b0;
                end else begin
                    r_idx <= r_idx + AW'(1);
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op         <= i_in.op;
                        r_val        <= i_in.value;
                        r_pri        <= i_in.priority_req;
                        r_res_status <= bpqel_pkg::ST_EMPTY;
                        r_res_val    <= '0;
                        r_res_pri    <= '0;
                        // Start a scan from entry zero.
                        r_idx        <= '0;
                        r_issue      <= (n_state == S_SCAN);
                        r_first      <= 1'b1;
                    end
                end
                S_APPEND: begin
                    r_stamp      <= r_stamp + SW'(1);
                    r_fill       <= r_fill + FW'(1);
                    r_res_status <= bpqel_pkg::ST_APPEND;
                end
                S_SCAN: begin
                    if (r_rd_vld) begin
                        r_first <= 1'b0;
                        if (w_take) begin
                            r_best_idx   <= r_rd_idx;
                            r_best_val   <= r_rd_val;
                            r_best_pri   <= r_rd_pri;
                            r_best_stamp <= r_rd_stamp;
                        end
                    end
                end
                S_DECIDE: begin
                    if (r_op == bpqel_pkg::OP_ENQ) begin
                        if (r_pri > r_best_pri) begin
                            r_stamp      <= r_stamp + SW'(1);
                            r_res_status <= bpqel_pkg::ST_REPLACE;
                        end else begin
                            r_res_status <= bpqel_pkg::ST_DROP;
                        end
                    end else begin
                        r_res_status <= bpqel_pkg::ST_REMOVE;
                        r_res_val    <= r_best_val;
                        r_res_pri    <= r_best_pri;
                        if (r_best_idx == w_last_idx) begin
                            r_fill <= r_fill - FW'(1);
                        end else begin
                            // Move later entries down, reading one ahead of the write.
                            r_idx    <= r_best_idx + AW'(1);
                            r_issue  <= 1'b1;
                        end
                    end
                end
                S_SHIFT: begin
                    if (w_scan_end) begin
                        r_fill <= r_fill - FW'(1);
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_val    <= r_res_val;
                        r_out_pri    <= r_res_pri;
                        r_out_fill   <= bpqel_pkg::FILL_W'(r_fill);
                    end
                end
                default: begin
                    r_first <= 1'b0;
                end
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.out_value    = r_out_val;
    assign o_out.out_priority = r_out_pri;
    assign o_out.fill         = r_out_fill;

    // The queue never holds more than the store's depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (FW'(DEPTH) >= r_fill))
        else $error("fill count above depth");

    // An accepted item always puts the sequencer to work.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("sequencer idle after accept");

    // A new result appears only out of the done state.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_out_valid)) |-> $past(r_state == S_DONE))
        else $error("result loaded outside done state");

    // Fill moves only on append, on removal of the tail, or at the end of a shift.
    a_fill_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_fill != $past(r_fill))) |->
            ($past(r_state == S_APPEND) || $past(r_state == S_DECIDE) ||
             $past(r_state == S_SHIFT)))
        else $error("fill changed outside a write step");

endmodule

`default_nettype wire

// ===== tb/bounded_priority_queue_evict_lowest_unit_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the bounded priority queue with lowest-priority eviction.
// A shadow queue predicts each result; depends on bpqel_pkg, bpqel_if and the unit RTL.

module bounded_priority_queue_evict_lowest_unit_test;

    localparam int          DEPTH_TB         = 16;
    localparam int unsigned CYCLE_LIMIT      = 1000000;
    localparam int unsigned SETTLE_CYCLES    = 4;
    localparam int unsigned LONG_HOLD_CYCLES = 400;
    localparam int          N_PHASES         = 10;
    localparam int          ITEMS_PER_PHASE  = 100;

    localparam logic signed [bpqel_pkg::VAL_W-1:0] VMIN = 32'sh8000_0000;
    localparam logic signed [bpqel_pkg::VAL_W-1:0] VMAX = 32'sh7fff_ffff;

    // One expected result item.
    typedef struct {
        bpqel_pkg::t_status                  status;
        logic signed [bpqel_pkg::VAL_W-1:0]  value;
        logic signed [bpqel_pkg::VAL_W-1:0]  prio;
        logic [bpqel_pkg::FILL_W-1:0]        fill;
    } t_pq_result;

    // Shadow copy of the queue: predicts each result and holds the ones still owed.
    class queue_shadow;
        logic signed [bpqel_pkg::VAL_W-1:0] held_value [DEPTH_TB];
        logic signed [bpqel_pkg::VAL_W-1:0] held_prio  [DEPTH_TB];
        logic [bpqel_pkg::STAMP_W-1:0]      held_stamp [DEPTH_TB];
        int unsigned                        held_count;
        logic [bpqel_pkg::STAMP_W-1:0]      stamp_next;
        logic [bpqel_pkg::CAP_W-1:0]        cap_reg;
        t_pq_result                         pending_results[$];
        int unsigned                        error_count;
        int unsigned                        status_seen[5];
        int unsigned                        peak_fill;
        int unsigned                        request_count;

        function new();
            held_count    = 0;
            stamp_next    = '0;
            cap_reg       = bpqel_pkg::CAP_RESET;
            error_count   = 0;
            peak_fill     = 0;
            request_count = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void set_capacity(logic [bpqel_pkg::CAP_W-1:0] cap);
            cap_reg = cap;
        endfunction

        // Zero behaves as one, anything beyond the store saturates.
        function int unsigned usable_capacity();
            int unsigned c;
            c = cap_reg;
            if (c == 0) c = 1;
            if (c > DEPTH_TB) c = DEPTH_TB;
            return c;
        endfunction

        function bpqel_pkg::t_status predict_enqueue(logic signed [bpqel_pkg::VAL_W-1:0] v,
                                                     logic signed [bpqel_pkg::VAL_W-1:0] p);
            int unsigned lowest;
            if (held_count < usable_capacity()) begin
                held_value[held_count] = v;
                held_prio[held_count]  = p;
                held_stamp[held_count] = stamp_next;
                stamp_next++;
                held_count++;
                return bpqel_pkg::ST_APPEND;
            end
            // Full path: scan every held entry, even above a lowered capacity.
            lowest = 0;
            for (int i = 1; i < held_count && i < DEPTH_TB; i++)
                if (held_prio[i] < held_prio[lowest]) lowest = i;
            if (p > held_prio[lowest]) begin
                held_value[lowest] = v;
                held_prio[lowest]  = p;
                held_stamp[lowest] = stamp_next;
                stamp_next++;
                return bpqel_pkg::ST_REPLACE;
            end
            return bpqel_pkg::ST_DROP;
        endfunction

        function bpqel_pkg::t_status predict_dequeue(
                output logic signed [bpqel_pkg::VAL_W-1:0] v,
                output logic signed [bpqel_pkg::VAL_W-1:0] p);
            int unsigned best;
            v = '0;
            p = '0;
            if (held_count == 0) return bpqel_pkg::ST_EMPTY;
            best = 0;
            for (int i = 1; i < held_count; i++)
                if (held_prio[i] > held_prio[best] ||
                    (held_prio[i] == held_prio[best] && held_stamp[i] < held_stamp[best]))
                    best = i;
            v = held_value[best];
            p = held_prio[best];
            for (int i = best; i + 1 < held_count; i++) begin
                held_value[i] = held_value[i+1];
                held_prio[i]  = held_prio[i+1];
                held_stamp[i] = held_stamp[i+1];
            end
            held_count--;
            return bpqel_pkg::ST_REMOVE;
        endfunction

        function void note_request(logic op, logic signed [bpqel_pkg::VAL_W-1:0] v,
                                   logic signed [bpqel_pkg::VAL_W-1:0] p);
            t_pq_result want;
            want.value = '0;
            want.prio  = '0;
            if (op == bpqel_pkg::OP_ENQ) want.status = predict_enqueue(v, p);
            else                         want.status = predict_dequeue(want.value, want.prio);
            want.fill = held_count[bpqel_pkg::FILL_W-1:0];
            if (held_count > peak_fill) peak_fill = held_count;
            status_seen[want.status]++;
            request_count++;
            pending_results = {pending_results, want};
        endfunction

        function void check_response(logic [bpqel_pkg::ST_W-1:0] st,
                                     logic signed [bpqel_pkg::VAL_W-1:0] ov,
                                     logic signed [bpqel_pkg::VAL_W-1:0] opr,
                                     logic [bpqel_pkg::FILL_W-1:0] fl);
            t_pq_result want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d value %0d priority %0d fill %0d",
                       st, ov, opr, fl);
                error_count++;
                return;
            end
            want = pending_results.pop_front();
            if (st !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, st);
                error_count++;
            end
            if (ov !== want.value) begin
                $error("out_value: expected %0d, got %0d", want.value, ov);
                error_count++;
            end
            if (opr !== want.prio) begin
                $error("out_priority: expected %0d, got %0d", want.prio, opr);
                error_count++;
            end
            if (fl !== want.fill) begin
                $error("fill: expected %0d, got %0d", want.fill, fl);
                error_count++;
            end
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [bpqel_pkg::CAP_W-1:0]   i_cfg_data;

    bpqel_in_if  req_if ();
    bpqel_out_if rsp_if ();

    queue_shadow shadow = new();

    // Idle controls for the request and result sides, and run counters.
    bit          src_quiet     = 1'b0;
    bit          sink_quiet    = 1'b0;
    bit          long_hold_req = 1'b0;
    int unsigned cycle_count   = 0;
    int unsigned cfg_writes    = 0;

    bounded_priority_queue_evict_lowest_unit #(
        .DEPTH (DEPTH_TB)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (req_if),
        .o_out      (rsp_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned idle_gap(bit quiet);
        int unsigned r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Priorities: clustered to force ties, the extremes, or anything at all.
    function automatic logic signed [bpqel_pkg::VAL_W-1:0] pick_priority();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return $signed($urandom_range(0, 6)) - 3;
        if (r < 60) begin
            case ($urandom_range(0, 5))
                0:       return VMIN;
                1:       return VMAX;
                2:       return VMIN + 1;
                3:       return VMAX - 1;
                4:       return '0;
                default: return -1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [bpqel_pkg::CAP_W-1:0] phase_capacity(int ph);
        case (ph)
            0:       return 5'd31;
            1:       return 5'd1;
            2:       return 5'd16;
            3:       return 5'd4;
            4:       return 5'd0;
            5:       return 5'd16;
            6:       return 5'd2;
            7:       return 5'd9;
            8:       return 5'd31;
            default: return 5'd3;
        endcase
    endfunction

    // Offer one item and hold it until the block takes it. Valid stays high on
    // return so a back-to-back item never lowers and raises it in one step.
    task automatic send_item(logic op, logic signed [bpqel_pkg::VAL_W-1:0] v,
                             logic signed [bpqel_pkg::VAL_W-1:0] p);
        int unsigned gap;
        gap = idle_gap(src_quiet);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.op           <= op;
        req_if.value        <= v;
        req_if.priority_req <= p;
        do @(posedge i_clk); while (!req_if.ready);
        shadow.note_request(op, v, p);
    endtask

    // Drop valid and wait until every owed result is back, then let the block settle.
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (shadow.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Capacity is only written with the block idle.
    task automatic write_capacity(logic [bpqel_pkg::CAP_W-1:0] cap);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cap;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        shadow.set_capacity(cap);
        cfg_writes++;
    endtask

    // Result side: check each accepted item, stall at random, and honor a
    // long hold-off on request so the block backs up into its input.
    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready)
                shadow.check_response(rsp_if.status, rsp_if.out_value,
                                      rsp_if.out_priority, rsp_if.fill);
            if (stall_left != 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD_CYCLES - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
                if (!sink_quiet && $urandom_range(0, 3) == 0) stall_left = idle_gap(1'b0);
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $error("run exceeded %0d cycles", CYCLE_LIMIT);
        $display("FAIL bounded_priority_queue_evict_lowest_unit");
        $finish;
    end

    initial begin : stimulus
        logic                               op;
        logic signed [bpqel_pkg::VAL_W-1:0] v;
        logic signed [bpqel_pkg::VAL_W-1:0] p;
        int unsigned                        enq_pct;

        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_data          <= '0;
        req_if.valid        <= 1'b0;
        req_if.op           <= bpqel_pkg::OP_ENQ;
        req_if.value        <= '0;
        req_if.priority_req <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset capacity: empty dequeue, field extremes, tie broken by age.
        send_item(bpqel_pkg::OP_DEQ, $urandom, $urandom);
        send_item(bpqel_pkg::OP_ENQ, VMAX, VMIN);
        send_item(bpqel_pkg::OP_ENQ, VMIN, VMAX);
        send_item(bpqel_pkg::OP_ENQ, '0, '0);
        send_item(bpqel_pkg::OP_ENQ, -1, '0);
        send_item(bpqel_pkg::OP_DEQ, $urandom, $urandom);
        send_item(bpqel_pkg::OP_DEQ, $urandom, $urandom);
        send_item(bpqel_pkg::OP_DEQ, $urandom, $urandom);
        send_item(bpqel_pkg::OP_DEQ, $urandom, $urandom);
        send_item(bpqel_pkg::OP_DEQ, $urandom, $urandom);

        // Capacity zero acts as one: replace only on a strictly higher priority.
        write_capacity(5'd0);
        send_item(bpqel_pkg::OP_ENQ, 32'sd11, 32'sd5);
        send_item(bpqel_pkg::OP_ENQ, 32'sd12, 32'sd7);
        send_item(bpqel_pkg::OP_ENQ, 32'sd13, 32'sd7);
        send_item(bpqel_pkg::OP_ENQ, 32'sd14, -32'sd3);
        send_item(bpqel_pkg::OP_DEQ, $urandom, $urandom);
        send_item(bpqel_pkg::OP_DEQ, $urandom, $urandom);

        // Lower capacity below fill: the full path scans all six held entries
        // and replaces the first of the two lowest.
        write_capacity(5'd16);
        send_item(bpqel_pkg::OP_ENQ, 32'sd21, 32'sd4);
        send_item(bpqel_pkg::OP_ENQ, 32'sd22, -32'sd2);
        send_item(bpqel_pkg::OP_ENQ, 32'sd23, 32'sd9);
        send_item(bpqel_pkg::OP_ENQ, 32'sd24, -32'sd2);
        send_item(bpqel_pkg::OP_ENQ, 32'sd25, 32'sd1);
        send_item(bpqel_pkg::OP_ENQ, 32'sd26, 32'sd3);
        write_capacity(5'd2);
        send_item(bpqel_pkg::OP_ENQ, 32'sd27, 32'sd0);
        send_item(bpqel_pkg::OP_ENQ, 32'sd28, -32'sd2);

        // Random phases: each picks a capacity, an enqueue mix and an idle style.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_capacity(phase_capacity(ph));
            enq_pct    = 75 - (ph % 3) * 15;
            src_quiet  = (ph % 4 == 1);
            sink_quiet = (ph % 4 == 1) || (ph % 4 == 2);
            if (ph == 3) long_hold_req = 1'b1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (ph == 6 && k == ITEMS_PER_PHASE / 2) wait_drained();
                op = ($urandom_range(0, 99) < enq_pct) ? bpqel_pkg::OP_ENQ
                                                       : bpqel_pkg::OP_DEQ;
                v  = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) != 0) ? VMIN : VMAX)
                                                 : $signed($urandom);
                p  = pick_priority();
                send_item(op, v, p);
            end
        end

        wait_drained();
        repeat (2 * DEPTH_TB + 8) @(posedge i_clk);

        $display("Run covered %0d requests over %0d capacity writes, peak fill %0d.",
                 shadow.request_count, cfg_writes, shadow.peak_fill);
        $display("Appended %0d, replaced %0d, dropped %0d, removed %0d, empty %0d.",
                 shadow.status_seen[bpqel_pkg::ST_APPEND],
                 shadow.status_seen[bpqel_pkg::ST_REPLACE],
                 shadow.status_seen[bpqel_pkg::ST_DROP],
                 shadow.status_seen[bpqel_pkg::ST_REMOVE],
                 shadow.status_seen[bpqel_pkg::ST_EMPTY]);
        if (shadow.error_count == 0 && shadow.pending_results.size() == 0)
            $display("PASS bounded_priority_queue_evict_lowest_unit");
        else
            $display("FAIL bounded_priority_queue_evict_lowest_unit");
        $finish;
    end

endmodule
